### design/tcgr_pkg.sv
// text cell glyph renderer package: payload structs, register indexes, defaults
// no dependencies
`default_nettype none

package tcgr_pkg;

	localparam int TCGR_MAX_GLYPH_WIDTH  = 16;
	localparam int TCGR_MAX_GLYPH_HEIGHT = 32;
	localparam int TCGR_SCREEN_COLUMNS   = 80;
	localparam int TCGR_SCREEN_ROWS      = 25;

	localparam int TCGR_GLYPH_BITS  = 16;
	localparam int TCGR_COLOR_W     = 4;
	localparam int TCGR_CODES       = 256;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;

	localparam logic [4:0] GLYPH_WIDTH_RESET  = 5'd8;
	localparam logic [5:0] GLYPH_HEIGHT_RESET = 6'd16;

	localparam logic MODE_RENDER = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  char_code;
		logic [7:0]  attribute;
		logic        blink_phase;
		logic [6:0]  cell_column;
		logic [4:0]  cell_row;
		logic [4:0]  load_row;
		logic [15:0] load_bits;
	} tcgr_in_t;

	typedef struct packed {
		logic [63:0] pixel_colors;
		logic [10:0] pixel_x;
		logic [9:0]  pixel_y;
		logic        last_row;
	} tcgr_out_t;

endpackage

`default_nettype wire

### design/text_cell_glyph_renderer.sv
// text cell glyph renderer top level: font load, line sequencer, pixel pipeline
// depends on tcgr_pkg and tcgr_ram
//
// usage:
//   in channel (in_valid / in_stall / in_data) takes load and render items.
//   a load item writes one glyph row into the font ram in the cycle of its
//   transfer and gives no result. a render item with a cell on screen gives
//   one result per glyph line on the out channel (out_valid / out_stall /
//   out_data), line 0 first, last_row set on the final line.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   glyph_width and glyph_height; cfg_ready is always high. write only while idle.
// sequencing:
//   a render item's lines pass the ram read (stage 1), glyph bits and width mask
//   (stage 2) and colors (stage 3) to out_data. the line sequencer issues one
//   font ram read per cycle unless out_stall holds it, and a render item holds
//   the in channel until its last glyph line is issued; a load item does not.
// reset: clears the pipeline valid bits and the sequencer, and sets the glyph
//   size registers to 8 by 16. font ram contents are undefined until loaded.
// stall: out_stall with out_valid high freezes the sequencer, the ram read port
//   and all stages; nothing is lost or repeated and out_data holds.
`default_nettype none

module text_cell_glyph_renderer
	import tcgr_pkg::*;
#(
	parameter int MAX_GLYPH_WIDTH  = TCGR_MAX_GLYPH_WIDTH,
	parameter int MAX_GLYPH_HEIGHT = TCGR_MAX_GLYPH_HEIGHT,
	parameter int SCREEN_COLUMNS   = TCGR_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS      = TCGR_SCREEN_ROWS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire tcgr_in_t               in_data,
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      tcgr_out_t              out_data,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int LINE_W  = $clog2(MAX_GLYPH_HEIGHT);
	localparam int DEPTH   = TCGR_CODES * (2 ** LINE_W);
	localparam int ADDR_W  = $clog2(DEPTH);

	// configuration
	logic [4:0] width_q;
	logic [5:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GLYPH_WIDTH_RESET;
			height_q <= GLYPH_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GLYPH_WIDTH:  width_q  <= cfg_data[4:0];
				CFG_GLYPH_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [4:0] w_clamp;
	logic [5:0] h_clamp;

	always_comb begin
		if (width_q == 5'd0) begin
			w_clamp = 5'd1;
		end else if (width_q > 5'(MAX_GLYPH_WIDTH)) begin
			w_clamp = 5'(MAX_GLYPH_WIDTH);
		end else begin
			w_clamp = width_q;
		end
		if (height_q == 6'd0) begin
			h_clamp = 6'd1;
		end else if (height_q > 6'(MAX_GLYPH_HEIGHT)) begin
			h_clamp = 6'(MAX_GLYPH_HEIGHT);
		end else begin
			h_clamp = height_q;
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, valid_s3;
	logic advance;

	assign advance = !valid_s3 || !out_stall;

	// input transfer
	logic active_q;
	logic in_xfer, on_screen, start_render, do_load;

	assign in_stall  = active_q;
	assign in_xfer   = in_valid && !in_stall;
	assign on_screen = ({1'b0, in_data.cell_column} < 8'(SCREEN_COLUMNS))
		&& ({1'b0, in_data.cell_row} < 6'(SCREEN_ROWS));
	assign start_render = in_xfer && (in_data.mode == MODE_RENDER) && on_screen;
	assign do_load = in_xfer && (in_data.mode == MODE_LOAD)
		&& ({1'b0, in_data.load_row} < 6'(MAX_GLYPH_HEIGHT));

	// attribute decode
	logic [3:0] fg_in, bg_in;

	always_comb begin
		fg_in = in_data.attribute[3:0];
		bg_in = in_data.attribute[7:4];
		if (bg_in[3]) begin
			bg_in = {1'b0, bg_in[2:0]};
			if (!in_data.blink_phase) begin
				fg_in = bg_in;
			end
		end
	end

	// line sequencer
	logic [7:0]        code_q;
	logic [3:0]        fg_q, bg_q;
	logic [4:0]        w_q;
	logic [5:0]        h_q;
	logic [10:0]       x_q;
	logic [9:0]        base_y_q;
	logic [LINE_W-1:0] line_q;
	logic              issue, last_issue;

	assign issue      = active_q && advance;
	assign last_issue = (6'(line_q) + 6'd1) == h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			line_q   <= '0;
		end else if (start_render) begin
			active_q <= 1'b1;
			line_q   <= '0;
		end else if (issue) begin
			line_q <= line_q + LINE_W'(1);
			if (last_issue) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_render) begin
			code_q   <= in_data.char_code;
			fg_q     <= fg_in;
			bg_q     <= bg_in;
			w_q      <= w_clamp;
			h_q      <= h_clamp;
			x_q      <= 11'(in_data.cell_column) * 11'(w_clamp);
			base_y_q <= 10'(in_data.cell_row) * 10'(h_clamp);
		end
	end

	// font ram
	logic [ADDR_W-1:0]          waddr, raddr;
	logic [TCGR_GLYPH_BITS-1:0] rdata;

	assign waddr = {in_data.char_code, in_data.load_row[LINE_W-1:0]};
	assign raddr = {code_q, line_q};

	tcgr_ram #(
		.WIDTH(TCGR_GLYPH_BITS),
		.DEPTH(DEPTH)
	) u_font_ram (
		.clk  (clk),
		.we   (do_load),
		.waddr(waddr),
		.wdata(in_data.load_bits),
		.re   (issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	// stage 1: ram read, side data
	logic [3:0]  fg_s1, bg_s1, fg_s2, bg_s2;
	logic [4:0]  w_s1;
	logic [10:0] x_s1, x_s2;
	logic [9:0]  y_s1, y_s2;
	logic        last_s1, last_s2;

	// stage 2: glyph bits and width mask
	logic [TCGR_GLYPH_BITS-1:0] on_s2, vis_s2;
	logic [TCGR_GLYPH_BITS-1:0] on_next, vis_next;

	always_comb begin
		for (int i = 0; i < TCGR_GLYPH_BITS; i++) begin
			vis_next[i] = 5'(i) < w_s1;
			on_next[i]  = rdata[TCGR_GLYPH_BITS-1-i];
		end
	end

	// stage 3: colors
	logic [63:0] colors_next;

	always_comb begin
		for (int i = 0; i < TCGR_GLYPH_BITS; i++) begin
			if (!vis_s2[i]) begin
				colors_next[TCGR_COLOR_W*i +: TCGR_COLOR_W] = '0;
			end else if (on_s2[i]) begin
				colors_next[TCGR_COLOR_W*i +: TCGR_COLOR_W] = fg_s2;
			end else begin
				colors_next[TCGR_COLOR_W*i +: TCGR_COLOR_W] = bg_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fg_s1   <= fg_q;
			bg_s1   <= bg_q;
			w_s1    <= w_q;
			x_s1    <= x_q;
			y_s1    <= base_y_q + 10'(line_q);
			last_s1 <= last_issue;

			on_s2   <= on_next;
			vis_s2  <= vis_next;
			fg_s2   <= fg_s1;
			bg_s2   <= bg_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;

			out_data.pixel_colors <= colors_next;
			out_data.pixel_x      <= x_s2;
			out_data.pixel_y      <= y_s2;
			out_data.last_row     <= last_s2;
		end
	end

	assign out_valid = valid_s3;

endmodule

`default_nettype wire

### design/tcgr_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tcgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### tb/text_cell_glyph_renderer_test.sv
`timescale 1ns / 100ps
// testbench for text_cell_glyph_renderer: loads glyph rows, renders text cells over several
// glyph sizes and checks every pixel row against a scoreboard that predicts the block
// depends on tcgr_pkg and the design files under design/

module text_cell_glyph_renderer_test;
	import tcgr_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int SETTLE_CYCLES   = TCGR_MAX_GLYPH_HEIGHT + 8;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int MAX_REPORTS     = 40;
	localparam int STORE_DEPTH     = TCGR_CODES * TCGR_MAX_GLYPH_HEIGHT;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

	class glyph_scoreboard;
		tcgr_out_t   rows_due[$];
		logic [15:0] font [STORE_DEPTH];
		bit          written [STORE_DEPTH];
		logic [4:0]  width_reg = GLYPH_WIDTH_RESET;
		logic [5:0]  height_reg = GLYPH_HEIGHT_RESET;
		int          errors;
		int          loads;
		int          renders;
		int          rows_checked;

		function int clamp_size(int v, int top);
			if (v < 1)
				return 1;
			if (v > top)
				return top;
			return v;
		endfunction

		function int width_used();
			return clamp_size(width_reg, TCGR_MAX_GLYPH_WIDTH);
		endfunction

		function int height_used();
			return clamp_size(height_reg, TCGR_MAX_GLYPH_HEIGHT);
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_GLYPH_WIDTH)
				width_reg = data[4:0];
			else if (index == CFG_GLYPH_HEIGHT)
				height_reg = data;
		endfunction

		function bit glyph_ready(logic [7:0] code);
			for (int r = 0; r < height_used(); r++)
				if (!written[code * TCGR_MAX_GLYPH_HEIGHT + r])
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_input(tcgr_in_t it);
			int          w;
			int          h;
			int          addr;
			int          px;
			int          py;
			logic [3:0]  fg;
			logic [3:0]  bg;
			logic [15:0] bits;
			tcgr_out_t   row;
			if (it.mode == MODE_LOAD) begin
				addr = it.char_code * TCGR_MAX_GLYPH_HEIGHT + it.load_row;
				font[addr] = it.load_bits;
				written[addr] = 1'b1;
				loads++;
				return;
			end
			renders++;
			if (it.cell_column >= TCGR_SCREEN_COLUMNS || it.cell_row >= TCGR_SCREEN_ROWS)
				return;
			w = width_used();
			h = height_used();
			fg = it.attribute[3:0];
			bg = it.attribute[7:4];
			// blink bit: dropped from background, hides foreground in phase 0
			if (bg[3]) begin
				bg[3] = 1'b0;
				if (!it.blink_phase)
					fg = bg;
			end
			px = it.cell_column * w;
			for (int line = 0; line < h; line++) begin
				bits = font[it.char_code * TCGR_MAX_GLYPH_HEIGHT + line];
				row.pixel_colors = '0;
				for (int i = 0; i < w; i++)
					row.pixel_colors[4*i +: 4] = bits[15-i] ? fg : bg;
				py = it.cell_row * h + line;
				row.pixel_x = px[10:0];
				row.pixel_y = py[9:0];
				row.last_row = (line == h - 1);
				rows_due.push_back(row);
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s expected %h got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(tcgr_out_t got);
			tcgr_out_t want;
			if (rows_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected row, expected none got %h", $time, got);
				return;
			end
			want = rows_due.pop_front();
			rows_checked++;
			compare_field("pixel_colors", want.pixel_colors, got.pixel_colors);
			compare_field("pixel_x", want.pixel_x, got.pixel_x);
			compare_field("pixel_y", want.pixel_y, got.pixel_y);
			compare_field("last_row", want.last_row, got.last_row);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	tcgr_in_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	tcgr_out_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	glyph_scoreboard sb = new();
	bit              tx_calm;
	bit              rx_calm;
	logic [7:0]      build_code;

	text_cell_glyph_renderer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	initial begin
		#(1_000_000 * 2 * HALF_PERIOD);
		$display("end of test: mismatches");
		$finish;
	end

	// result side: random stall after each transfer
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
			sb.check_result(out_data);
		end
	end

	task automatic push_item(input tcgr_in_t it);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_input(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.rows_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic push_render(input logic [7:0] attr, input logic phase,
			input logic [6:0] col, input logic [4:0] row);
		tcgr_in_t it;
		it = '0;
		it.mode = MODE_RENDER;
		it.char_code = 8'hFF;
		it.attribute = attr;
		it.blink_phase = phase;
		it.cell_column = col;
		it.cell_row = row;
		push_item(it);
	endtask

	function automatic int next_row(logic [7:0] code);
		for (int r = 0; r < TCGR_MAX_GLYPH_HEIGHT; r++)
			if (!sb.written[code * TCGR_MAX_GLYPH_HEIGHT + r])
				return r;
		return -1;
	endfunction

	// mostly glyph builds and renders of fully loaded glyphs, some stray loads and off-screen cells
	task automatic random_item(output tcgr_in_t it);
		logic [63:0] raw;
		logic [7:0]  ready_codes[$];
		int          row;
		raw = {$urandom(), $urandom()};
		it = raw[$bits(tcgr_in_t)-1:0];
		for (int c = 0; c < TCGR_CODES; c++)
			if (sb.glyph_ready(c[7:0]))
				ready_codes.push_back(c[7:0]);
		if (ready_codes.size() == 0 || $urandom_range(0, 9) < 3) begin
			it.mode = MODE_LOAD;
			if (ready_codes.size() == 0 || $urandom_range(0, 4) != 0) begin
				row = next_row(build_code);
				if (row < 0) begin
					build_code = 8'($urandom_range(0, 255));
					row = next_row(build_code);
					if (row < 0)
						row = 0;
				end
				it.char_code = build_code;
				it.load_row = row[4:0];
			end
		end else begin
			it.mode = MODE_RENDER;
			it.char_code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
			case ($urandom_range(0, 9))
				0: it.cell_column = 7'($urandom_range(TCGR_SCREEN_COLUMNS, 127));
				1: it.cell_row = 5'($urandom_range(TCGR_SCREEN_ROWS, 31));
				default: begin
					it.cell_column = 7'($urandom_range(0, TCGR_SCREEN_COLUMNS - 1));
					it.cell_row = 5'($urandom_range(0, TCGR_SCREEN_ROWS - 1));
				end
			endcase
		end
	endtask

	initial begin
		tcgr_in_t    it;
		logic [15:0] patterns [8] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
			16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF};
		int          width_pick [PHASES] = '{16, 0, 1, 63, 17, -1, -1};
		int          height_pick [PHASES] = '{32, 0, 1, 63, 33, -1, -1};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GLYPH_WIDTH;
		cfg_data = '0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		build_code = 8'hFF;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default 8x16 glyph with edge patterns, then blink, corner and off-screen cells
		for (int r = 0; r < GLYPH_HEIGHT_RESET; r++) begin
			it = '0;
			it.mode = MODE_LOAD;
			it.char_code = 8'hFF;
			it.load_row = r[4:0];
			it.load_bits = (r < 8) ? patterns[r] : 16'($urandom());
			push_item(it);
		end
		push_render(8'h00, 1'b0, 7'd0, 5'd0);
		push_render(8'hFF, 1'b0, 7'd79, 5'd24);
		push_render(8'hFF, 1'b1, 7'd79, 5'd24);
		push_render(8'h7F, 1'b0, 7'd40, 5'd12);
		push_render(8'h9A, 1'b1, 7'd3, 5'd7);
		push_render(8'hA5, 1'b0, 7'd1, 5'd1);
		push_render(8'h3C, 1'b1, 7'd80, 5'd0);
		push_render(8'h3C, 1'b1, 7'd0, 5'd25);
		push_render(8'hC3, 1'b0, 7'd127, 5'd31);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			cfg_write(CFG_GLYPH_WIDTH, CFG_DATA_W'(
				width_pick[p] < 0 ? $urandom_range(1, 16) : width_pick[p]));
			cfg_write(CFG_GLYPH_HEIGHT, CFG_DATA_W'(
				height_pick[p] < 0 ? $urandom_range(1, 32) : height_pick[p]));
			cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
				CFG_DATA_W'($urandom()));
			tx_calm = (p == 2) || ($urandom_range(0, 4) == 0);
			rx_calm = (p == 2) || ($urandom_range(0, 4) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				random_item(it);
				push_item(it);
			end
		end
		drain();

		$display("%0d font row loads, %0d render requests, %0d pixel rows compared",
			sb.loads, sb.renders, sb.rows_checked);
		$display("glyph sizes from 1x1 to 16x32 incl. clamped register values, %0d errors",
			sb.errors);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
